### rtl/core/weas_pkg.sv
// ----------------------------------------------------------------------------
// Weekly event alarm scheduler package
// Shared types and constants for the alarm scheduler core and its cells.
// ----------------------------------------------------------------------------
package weas_pkg;

    localparam logic [1:0] CMD_TICK          = 2'd0;
    localparam logic [1:0] CMD_WRITE_EVENT   = 2'd1;
    localparam logic [1:0] CMD_WRITE_HOLIDAY = 2'd2;

    localparam logic [1:0] CFG_VAC_START = 2'd0;
    localparam logic [1:0] CFG_VAC_END   = 2'd1;

    localparam logic [31:0] DAY_SECONDS  = 32'd86400;
    localparam logic [31:0] HOUR_SECONDS = 32'd3600;
    localparam logic [21:0] SECS_PER_MIN = 22'd60;
    localparam logic [16:0] DAILY_WINDOW = 17'd30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLIDAY,
        ST_EVENT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        enabled;
        logic        periodic;
        logic [15:0] minute;
        logic [7:0]  weekdays;
        logic        on_holiday;
        logic        on_vacation;
    } t_entry;

    typedef struct packed {
        logic       we;
        logic [2:0] slot;
        t_entry     entry;
    } t_event_wr;

    typedef struct packed {
        logic        we;
        logic [2:0]  slot;
        logic [31:0] date;
    } t_holiday_wr;

    typedef struct packed {
        logic        go;
        logic [31:0] now;
        logic        hit;
    } t_htok;

    typedef struct packed {
        logic        go;
        logic [31:0] now;
        logic [10:0] mod;
        logic [2:0]  wd;
        logic        holiday;
        logic        vacation;
    } t_etok;

endpackage

### rtl/core/weas_holiday_cell.sv
// ----------------------------------------------------------------------------
// Holiday cell
// Holds one holiday date and folds its day test into the passing token.
// ----------------------------------------------------------------------------
module weas_holiday_cell
    import weas_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_holiday_wr i_wr,
    input  t_htok       i_tok,
    output t_htok       o_tok
);

    logic [31:0] r_date;
    t_htok       r_tok;
    logic        in_day;

    assign in_day = (i_tok.now > r_date) && (i_tok.now < (r_date + DAY_SECONDS));

    always_ff @(posedge i_clk) begin
        r_tok.now <= i_tok.now;
        r_tok.hit <= i_tok.hit | in_day;
        if (!i_rst_n) begin
            r_date   <= '0;
            r_tok.go <= 1'b0;
        end else begin
            if (i_wr.we && (32'(i_wr.slot) == 32'(IDX))) begin
                r_date <= i_wr.date;
            end
            r_tok.go <= i_tok.go;
        end
    end

    assign o_tok = r_tok;

endmodule

### rtl/core/weas_event_cell.sv
// ----------------------------------------------------------------------------
// Event cell
// Holds one alarm entry with its last firing time and tests it as the tick
// token passes.
// ----------------------------------------------------------------------------
module weas_event_cell
    import weas_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_event_wr i_wr,
    input  t_etok     i_tok,
    output t_etok     o_tok,
    output logic      o_fire
);

    t_entry      r_entry;
    logic [31:0] r_last;
    t_etok       r_tok;

    logic [21:0] period_s;
    logic [31:0] back;
    logic        in_window;
    logic        old_enough;
    logic        day_ok;
    logic        fire;

    always_comb begin
        period_s   = 22'(r_entry.minute) * SECS_PER_MIN;
        back       = i_tok.now - 32'(period_s);
        in_window  = (16'(i_tok.mod) >= r_entry.minute) &&
                     (17'(i_tok.mod) < (17'(r_entry.minute) + DAILY_WINDOW));
        old_enough = r_last < (i_tok.now - HOUR_SECONDS);
        day_ok     = (i_tok.holiday && r_entry.on_holiday) ||
                     (i_tok.vacation && r_entry.on_vacation) ||
                     r_entry.weekdays[i_tok.wd];
        fire       = i_tok.go && r_entry.enabled &&
                     (r_entry.periodic ? (r_last <= back)
                                       : (in_window && old_enough && day_ok));
    end

    always_ff @(posedge i_clk) begin
        r_tok.now      <= i_tok.now;
        r_tok.mod      <= i_tok.mod;
        r_tok.wd       <= i_tok.wd;
        r_tok.holiday  <= i_tok.holiday;
        r_tok.vacation <= i_tok.vacation;
        if (!i_rst_n) begin
            r_entry  <= '0;
            r_last   <= '0;
            r_tok.go <= 1'b0;
        end else begin
            if (i_wr.we && (32'(i_wr.slot) == 32'(IDX))) begin
                r_entry <= i_wr.entry;
            end
            if (fire) begin
                r_last <= i_tok.now;
            end
            r_tok.go <= i_tok.go;
        end
    end

    assign o_tok  = r_tok;
    assign o_fire = fire;

endmodule

### rtl/core/weekly_event_alarm_scheduler_core.sv
// ----------------------------------------------------------------------------
// Weekly event alarm scheduler core
// Checks a row of alarm entries on every tick and reports the ones that fire.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall) and
// carry a command. A write of an entry or a holiday date takes effect in the
// cycle it is accepted and produces no result. A tick sends a token first
// along the row of holiday cells, one cell per cycle, then along the row of
// alarm cells, one cell per cycle, then walks the fire mask one index per
// cycle, waiting at a fired entry while the result register is held, and
// emits one result per fired entry in ascending index order, with
// o_out_last_fired set on the last one. A tick therefore occupies the core
// until both cell rows are passed and the result scan is done. Input stall is
// held high for that whole time. A tick with no firing entry gives no result.
// The result register holds its value while i_out_stall is high, and the
// scan waits for it. The vacation registers are written through the cfg
// channel, which is always ready. Synchronous reset clears all entries, last
// firing times, holiday dates and the vacation registers.
// ----------------------------------------------------------------------------
module weekly_event_alarm_scheduler_core
    import weas_pkg::*;
#(
    parameter int unsigned EVENT_SLOTS   = 8,
    parameter int unsigned HOLIDAY_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_in_cmd,
    input  logic [31:0] i_in_time_seconds,
    input  logic [10:0] i_in_minute_now,
    input  logic [2:0]  i_in_weekday_now,
    input  logic [2:0]  i_in_slot,
    input  logic        i_in_entry_enabled,
    input  logic        i_in_entry_periodic,
    input  logic [15:0] i_in_entry_minute,
    input  logic [7:0]  i_in_entry_weekdays,
    input  logic        i_in_entry_on_holiday,
    input  logic        i_in_entry_on_vacation,
    input  logic [31:0] i_in_holiday_date,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_out_fired_index,
    output logic        o_out_last_fired
);

    localparam int unsigned IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

    t_state                 r_state;
    t_state                 n_state;
    logic [31:0]            r_vac_start;
    logic [31:0]            r_vac_end;
    logic [10:0]            r_mod;
    logic [2:0]             r_wd;
    t_htok                  r_htok;
    t_etok                  r_etok;
    logic [EVENT_SLOTS-1:0] r_mask;
    logic [IW-1:0]          r_idx;
    logic                   r_out_valid;
    logic [2:0]             r_out_index;
    logic                   r_out_last;

    t_htok                  htok [0:HOLIDAY_SLOTS];
    t_etok                  etok [0:EVENT_SLOTS];
    logic [EVENT_SLOTS-1:0] fire_vec;
    t_event_wr              ev_wr;
    t_holiday_wr            hol_wr;
    logic                   in_accept;
    logic                   tick_start;
    logic                   vacation;
    logic                   out_free;
    logic                   emit;
    logic [EVENT_SLOTS-1:0] mask_after;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign tick_start = in_accept && (i_in_cmd == CMD_TICK);

    always_comb begin
        ev_wr.we                = in_accept && (i_in_cmd == CMD_WRITE_EVENT);
        ev_wr.slot              = i_in_slot;
        ev_wr.entry.enabled     = i_in_entry_enabled;
        ev_wr.entry.periodic    = i_in_entry_periodic;
        ev_wr.entry.minute      = i_in_entry_minute;
        ev_wr.entry.weekdays    = i_in_entry_weekdays;
        ev_wr.entry.on_holiday  = i_in_entry_on_holiday;
        ev_wr.entry.on_vacation = i_in_entry_on_vacation;
        hol_wr.we               = in_accept && (i_in_cmd == CMD_WRITE_HOLIDAY);
        hol_wr.slot             = i_in_slot;
        hol_wr.date             = i_in_holiday_date;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vac_start <= '0;
            r_vac_end   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VAC_START: r_vac_start <= i_cfg_data;
                CFG_VAC_END:   r_vac_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign htok[0] = r_htok;
    assign vacation = (htok[HOLIDAY_SLOTS].now > r_vac_start) &&
                      (htok[HOLIDAY_SLOTS].now < (r_vac_end + DAY_SECONDS));

    always_ff @(posedge i_clk) begin
        if (tick_start) begin
            r_htok.now <= i_in_time_seconds;
            r_mod      <= i_in_minute_now;
            r_wd       <= i_in_weekday_now;
        end
        r_htok.hit     <= 1'b0;
        r_etok.now     <= htok[HOLIDAY_SLOTS].now;
        r_etok.mod     <= r_mod;
        r_etok.wd      <= r_wd;
        r_etok.holiday <= htok[HOLIDAY_SLOTS].hit;
        r_etok.vacation <= vacation;
        if (!i_rst_n) begin
            r_htok.go <= 1'b0;
            r_etok.go <= 1'b0;
        end else begin
            r_htok.go <= tick_start;
            r_etok.go <= htok[HOLIDAY_SLOTS].go;
        end
    end

    genvar g;
    generate
        for (g = 0; g < HOLIDAY_SLOTS; g++) begin : g_hol
            weas_holiday_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_wr   (hol_wr),
                .i_tok  (htok[g]),
                .o_tok  (htok[g+1])
            );
        end
    endgenerate

    assign etok[0] = r_etok;

    generate
        for (g = 0; g < EVENT_SLOTS; g++) begin : g_evt
            weas_event_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_wr   (ev_wr),
                .i_tok  (etok[g]),
                .o_tok  (etok[g+1]),
                .o_fire (fire_vec[g])
            );
        end
    endgenerate

    always_comb begin
        out_free          = !r_out_valid || !i_out_stall;
        mask_after        = r_mask;
        mask_after[r_idx] = 1'b0;
        emit              = 1'b0;
        n_state           = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_start) begin
                    n_state = ST_HOLIDAY;
                end
            end
            ST_HOLIDAY: begin
                if (htok[HOLIDAY_SLOTS].go) begin
                    n_state = ST_EVENT;
                end
            end
            ST_EVENT: begin
                if (etok[EVENT_SLOTS].go) begin
                    n_state = (r_mask == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_mask[r_idx]) begin
                    emit = out_free;
                    if (out_free && (mask_after == '0)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_idx  <= '0;
        end else if (tick_start) begin
            r_mask <= '0;
            r_idx  <= '0;
        end else if (r_state == ST_EVENT) begin
            r_mask <= r_mask | fire_vec;
        end else if (r_state == ST_EMIT) begin
            if (emit) begin
                r_mask <= mask_after;
                r_idx  <= r_idx + 1'b1;
            end else if (!r_mask[r_idx]) begin
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_index <= 3'(r_idx);
            r_out_last  <= (mask_after == '0);
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_fired_index = r_out_index;
    assign o_out_last_fired  = r_out_last;

endmodule

### rtl/core/weas_checker.sv
// ----------------------------------------------------------------------------
// Alarm scheduler port checker
// Watches the core's ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module weas_checker
    import weas_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_in_cmd,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_out_fired_index,
    input logic       o_out_last_fired
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_out_fired_index) && $stable(o_out_last_fired)))
        else $error("Stalled result changed.");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("Core not quiet after reset.");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_cmd == CMD_TICK)) |=> o_in_stall)
        else $error("Tick did not occupy the core.");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_cmd != CMD_TICK)) |=> !o_in_stall)
        else $error("Write request occupied the core.");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_last_fired) |-> o_in_stall)
        else $error("Result sequence ended without a last mark.");

endmodule

bind weekly_event_alarm_scheduler_core weas_checker u_weas_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_in_cmd         (i_in_cmd),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_fired_index(o_out_fired_index),
    .o_out_last_fired (o_out_last_fired)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weekly event alarm scheduler core testbench
// Sends ticks, alarm entry writes, holiday writes and vacation register writes
// into the core. A model of the alarm table predicts which entries fire on
// each tick, and every result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
    import weas_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int NUM_ENTRIES    = 8;
    localparam int NUM_HOLIDAYS   = 4;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 52;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [10:0] mod;
        logic [2:0]  wd;
        logic [2:0]  slot;
        t_entry      entry;
        logic [31:0] holiday_date;
    } t_request;

    typedef struct packed {
        logic [2:0] index;
        logic       last;
    } t_firing;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_in_cmd = '0;
    logic [31:0] i_in_time_seconds = '0;
    logic [10:0] i_in_minute_now = '0;
    logic [2:0]  i_in_weekday_now = '0;
    logic [2:0]  i_in_slot = '0;
    logic        i_in_entry_enabled = 1'b0;
    logic        i_in_entry_periodic = 1'b0;
    logic [15:0] i_in_entry_minute = '0;
    logic [7:0]  i_in_entry_weekdays = '0;
    logic        i_in_entry_on_holiday = 1'b0;
    logic        i_in_entry_on_vacation = 1'b0;
    logic [31:0] i_in_holiday_date = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_out_fired_index;
    logic        o_out_last_fired;

    t_entry      alarm_table[NUM_ENTRIES];
    logic [31:0] fire_time[NUM_ENTRIES];
    logic [31:0] holiday_dates[NUM_HOLIDAYS];
    logic [31:0] vac_start_q;
    logic [31:0] vac_end_q;
    t_firing     pending_firings[$];
    t_firing     want;

    logic [31:0] clock_now = 32'd1700000000;
    int          stall_mode = 0;
    int          stall_run = 0;
    bit          steady_sender = 1'b0;
    int          burst_left = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          tick_count = 0;
    int          write_count = 0;
    int          other_count = 0;
    int          cfg_count = 0;
    int          result_count = 0;

    weekly_event_alarm_scheduler_core u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_in_cmd               (i_in_cmd),
        .i_in_time_seconds      (i_in_time_seconds),
        .i_in_minute_now        (i_in_minute_now),
        .i_in_weekday_now       (i_in_weekday_now),
        .i_in_slot              (i_in_slot),
        .i_in_entry_enabled     (i_in_entry_enabled),
        .i_in_entry_periodic    (i_in_entry_periodic),
        .i_in_entry_minute      (i_in_entry_minute),
        .i_in_entry_weekdays    (i_in_entry_weekdays),
        .i_in_entry_on_holiday  (i_in_entry_on_holiday),
        .i_in_entry_on_vacation (i_in_entry_on_vacation),
        .i_in_holiday_date      (i_in_holiday_date),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_out_fired_index      (o_out_fired_index),
        .o_out_last_fired       (o_out_last_fired)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("weekly_event_alarm_scheduler_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_mode == 0) begin
            i_out_stall <= 1'b0;
        end else if (stall_mode == 1) begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
        end else if (stall_run == 0) begin
            stall_run   <= $urandom_range(1, 12);
            i_out_stall <= ~i_out_stall;
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (pending_firings.size() == 0) begin
                $error("unexpected result: fired_index %0d last_fired %0b",
                       o_out_fired_index, o_out_last_fired);
                fail_count++;
            end else begin
                want = pending_firings.pop_front();
                if (o_out_fired_index !== want.index) begin
                    $error("fired_index: expected %0d, actual %0d",
                           want.index, o_out_fired_index);
                    fail_count++;
                end
                if (o_out_last_fired !== want.last) begin
                    $error("last_fired: expected %0b, actual %0b",
                           want.last, o_out_last_fired);
                    fail_count++;
                end
            end
        end
    end

    function automatic void predict_alarms(input t_request req);
        logic        holiday;
        logic        vacation;
        logic        fire;
        logic [31:0] day_end;
        logic [31:0] back;
        logic [31:0] hour_ago;
        logic [16:0] window_end;
        t_entry      e;
        t_firing     f;
        int          n;
        n = 0;
        case (req.cmd)
            CMD_WRITE_EVENT: begin
                alarm_table[req.slot] = req.entry;
            end
            CMD_WRITE_HOLIDAY: begin
                if (req.slot < NUM_HOLIDAYS) holiday_dates[req.slot] = req.holiday_date;
            end
            CMD_TICK: begin
                holiday = 1'b0;
                for (int h = 0; h < NUM_HOLIDAYS; h++) begin
                    day_end = holiday_dates[h] + DAY_SECONDS;
                    if (req.now > holiday_dates[h] && req.now < day_end) holiday = 1'b1;
                end
                day_end  = vac_end_q + DAY_SECONDS;
                vacation = (req.now > vac_start_q) && (req.now < day_end);
                hour_ago = req.now - HOUR_SECONDS;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    e    = alarm_table[i];
                    fire = 1'b0;
                    if (e.enabled && e.periodic) begin
                        back = req.now - 32'(e.minute) * 32'd60;
                        fire = (fire_time[i] <= back);
                    end else if (e.enabled) begin
                        window_end = {1'b0, e.minute} + 17'd30;
                        if (17'(req.mod) >= {1'b0, e.minute} && 17'(req.mod) < window_end &&
                            fire_time[i] < hour_ago) begin
                            fire = (holiday && e.on_holiday) || (vacation && e.on_vacation) ||
                                   e.weekdays[req.wd];
                        end
                    end
                    if (fire) begin
                        fire_time[i] = req.now;
                        f.index = 3'(i);
                        f.last  = 1'b0;
                        pending_firings.push_back(f);
                        n++;
                    end
                end
                if (n > 0) pending_firings[pending_firings.size() - 1].last = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_request random_request();
        t_request req;
        req.cmd          = CMD_UNUSED;
        req.now          = $urandom();
        req.mod          = 11'($urandom());
        req.wd           = 3'($urandom());
        req.slot         = 3'($urandom());
        req.entry        = 28'($urandom());
        req.holiday_date = $urandom();
        return req;
    endfunction

    function automatic t_request tick_request(input logic [31:0] now, input logic [10:0] mod,
                                              input logic [2:0] wd);
        t_request req;
        req     = random_request();
        req.cmd = CMD_TICK;
        req.now = now;
        req.mod = mod;
        req.wd  = wd;
        return req;
    endfunction

    // Minute of day and weekday follow from the epoch seconds; day zero was a Thursday.
    function automatic t_request calendar_tick(input logic [31:0] now);
        return tick_request(now, 11'((now / 32'd60) % 32'd1440),
                            3'(((now / 32'd86400) + 32'd4) % 32'd7 + 32'd1));
    endfunction

    function automatic t_request entry_request(input logic [2:0] slot, input logic en,
                                               input logic periodic, input logic [15:0] minute,
                                               input logic [7:0] weekdays, input logic on_hol,
                                               input logic on_vac);
        t_request req;
        req                   = random_request();
        req.cmd               = CMD_WRITE_EVENT;
        req.slot              = slot;
        req.entry.enabled     = en;
        req.entry.periodic    = periodic;
        req.entry.minute      = minute;
        req.entry.weekdays    = weekdays;
        req.entry.on_holiday  = on_hol;
        req.entry.on_vacation = on_vac;
        return req;
    endfunction

    function automatic t_request holiday_request(input logic [2:0] slot,
                                                 input logic [31:0] date);
        t_request req;
        req              = random_request();
        req.cmd          = CMD_WRITE_HOLIDAY;
        req.slot         = slot;
        req.holiday_date = date;
        return req;
    endfunction

    task automatic send_request(input t_request req);
        int gap;
        i_in_valid             <= 1'b1;
        i_in_cmd               <= req.cmd;
        i_in_time_seconds      <= req.now;
        i_in_minute_now        <= req.mod;
        i_in_weekday_now       <= req.wd;
        i_in_slot              <= req.slot;
        i_in_entry_enabled     <= req.entry.enabled;
        i_in_entry_periodic    <= req.entry.periodic;
        i_in_entry_minute      <= req.entry.minute;
        i_in_entry_weekdays    <= req.entry.weekdays;
        i_in_entry_on_holiday  <= req.entry.on_holiday;
        i_in_entry_on_vacation <= req.entry.on_vacation;
        i_in_holiday_date      <= req.holiday_date;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_alarms(req);
        if (req.cmd == CMD_TICK) tick_count++;
        else if (req.cmd == CMD_UNUSED) other_count++;
        else write_count++;
        if (!steady_sender) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_block();
        release_input();
        while (pending_firings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_VAC_START) vac_start_q = data;
        else if (index == CFG_VAC_END) vac_end_q = data;
        cfg_count++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        write_register(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_register(CFG_SPARE_B, $urandom());
        stall_mode = 1;
        send_request(tick_request(32'd0, 11'd0, 3'd0));
        send_request(tick_request(32'hFFFF_FFFF, 11'h7FF, 3'd7));
        send_request(random_request());
        drain_block();
    endtask

    // Covers interval entries at both period extremes, the weekday zero bit, a daily
    // window that cannot be reached, a zero holiday slot, an ignored holiday slot and
    // time values small enough that the look-back wraps.
    task automatic test_table_corners();
        send_request(entry_request(3'd0, 1'b1, 1'b1, 16'd0, 8'h00, 1'b0, 1'b0));
        send_request(entry_request(3'd7, 1'b1, 1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_request(entry_request(3'd3, 1'b1, 1'b0, 16'd480, 8'h01, 1'b0, 1'b0));
        send_request(entry_request(3'd5, 1'b1, 1'b0, 16'd1439, 8'h00, 1'b1, 1'b0));
        send_request(entry_request(3'd6, 1'b1, 1'b0, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        send_request(entry_request(3'd2, 1'b0, 1'b0, 16'd600, 8'hFF, 1'b1, 1'b1));
        send_request(holiday_request(3'd0, 32'd1000000));
        send_request(holiday_request(3'd6, 32'd2000000));
        send_request(tick_request(32'd1000100, 11'd1450, 3'd0));
        send_request(tick_request(32'd1000110, 11'd1460, 3'd0));
        send_request(tick_request(32'd5000, 11'd490, 3'd0));
        send_request(tick_request(32'd100, 11'd500, 3'd0));
        send_request(tick_request(32'hFFFF_FFFF, 11'h7FF, 3'd7));
        drain_block();
    endtask

    task automatic test_vacation_window();
        write_register(CFG_VAC_START, 32'd2000000);
        write_register(CFG_VAC_END, 32'd2086400);
        stall_mode = 2;
        send_request(entry_request(3'd4, 1'b1, 1'b0, 16'd600, 8'h00, 1'b0, 1'b1));
        send_request(tick_request(32'd2100000, 11'd610, 3'd3));
        send_request(tick_request(32'd2200000, 11'd615, 3'd3));
        drain_block();
    endtask

    task automatic test_random_schedule();
        t_request    req;
        logic [31:0] vac_a;
        logic [31:0] vac_b;
        logic [10:0] cur_mod;
        int          pick;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_block();
            case (p)
                0: begin
                    vac_a = 32'd0;
                    vac_b = 32'd0;
                end
                1: begin
                    vac_a = 32'hFFFF_FFFF;
                    vac_b = 32'hFFFF_FFFF;
                end
                2, 4: begin
                    vac_a = clock_now - 32'd86400 * $urandom_range(0, 2);
                    vac_b = clock_now + 32'd86400 * $urandom_range(0, 2);
                end
                default: begin
                    vac_a = $urandom();
                    vac_b = $urandom();
                end
            endcase
            write_register(CFG_VAC_START, vac_a);
            write_register(CFG_VAC_END, vac_b);
            stall_mode    = p % 3;
            steady_sender = (p == 3);
            for (int k = 0; k < PHASE_REQUESTS; k++) begin
                if (p == 2 && k == PHASE_REQUESTS / 2) drain_block();
                cur_mod = 11'((clock_now / 32'd60) % 32'd1440);
                pick    = $urandom_range(0, 99);
                if (pick < 62) begin
                    if ($urandom_range(0, 9) == 0) clock_now += $urandom_range(3600, 200000);
                    else clock_now += $urandom_range(60, 2400);
                    req = calendar_tick(clock_now);
                end else if (pick < 72) begin
                    req     = random_request();
                    req.cmd = CMD_TICK;
                end else if (pick < 88) begin
                    req = random_request();
                    req.cmd = CMD_WRITE_EVENT;
                    req.entry.enabled = ($urandom_range(0, 4) != 0);
                    if ($urandom_range(0, 9) != 0) begin
                        if (req.entry.periodic) begin
                            req.entry.minute = 16'($urandom_range(1, 90));
                        end else begin
                            req.entry.minute =
                                16'((int'(cur_mod) + 1440 - $urandom_range(0, 40)) % 1440);
                        end
                    end
                end else if (pick < 96) begin
                    req = holiday_request(3'($urandom()), $urandom());
                    if ($urandom_range(0, 1) == 0) begin
                        req.holiday_date = clock_now - clock_now % 32'd86400;
                    end else if ($urandom_range(0, 2) == 0) begin
                        req.holiday_date = 32'd0;
                    end
                end else begin
                    req = random_request();
                end
                send_request(req);
            end
        end
        release_input();
    endtask

    initial begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            alarm_table[i] = '0;
            fire_time[i]   = '0;
        end
        for (int h = 0; h < NUM_HOLIDAYS; h++) holiday_dates[h] = '0;
        vac_start_q = '0;
        vac_end_q   = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_table_corners();
        test_vacation_window();
        test_random_schedule();
        drain_block();
        $display("Covered %0d ticks, %0d table writes and %0d unknown requests; %0d alarms checked.",
                 tick_count, write_count, other_count, result_count);
        $display("Made %0d register writes, with vacation bounds at both extremes.", cfg_count);
        if (fail_count == 0) begin
            $display("weekly_event_alarm_scheduler_core regression: pass");
        end else begin
            $display("weekly_event_alarm_scheduler_core regression: fail");
        end
        $finish;
    end

endmodule
